// ===== design/lucas_kanade_dense_flow_defines.svh =====
// Assertion macros for the dense optical flow block.
// Used by the top level; expects clk and rst in the scope of each use.
`ifndef LUCAS_KANADE_DENSE_FLOW_DEFINES_SVH
`define LUCAS_KANADE_DENSE_FLOW_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define LKDF_ASSERT_IMP(name, pre, con) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |-> (con)) \
    else $error("lkdf assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define LKDF_ASSERT_NXT(name, pre, con) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (con)) \
    else $error("lkdf assertion failed");

`endif

// ===== design/lkdf_pkg.sv =====
// Shared types and constants of the dense optical flow block.
// No dependencies; every module file imports it.
package lkdf_pkg;

  localparam int DEF_MAX_WIDTH     = 1024;
  localparam int DEF_WINDOW_SIZE   = 5;
  localparam int DEF_FRACTION_BITS = 16;

  localparam int PIX_W     = 8;
  localparam int GRAD_W    = 11;
  localparam int ENTRY_W   = 3 * GRAD_W;
  localparam int FLOW_W    = 32;
  localparam int ROW_W     = 12;
  localparam int OUT_COL_W = 10;
  localparam int DIM_W     = 14;
  localparam int MIN_DIM   = 8;
  localparam int MAX_HEIGHT = 4096;
  localparam int WIDTH_REG_W  = 11;
  localparam int HEIGHT_REG_W = 13;
  localparam int NUM_SUMS  = 5;

  localparam logic [WIDTH_REG_W-1:0]  RESET_WIDTH  = 11'd640;
  localparam logic [HEIGHT_REG_W-1:0] RESET_HEIGHT = 13'd480;

  localparam logic REG_IMAGE_WIDTH  = 1'b0;
  localparam logic REG_IMAGE_HEIGHT = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE, ST_GRAD, ST_MAC, ST_RED, ST_MUL, ST_DIFF, ST_CHK, ST_DIV, ST_OUT
  } state_t;

  typedef struct packed {
    logic capture;
    logic commit;
    logic grad_on;
  } front_ctrl_t;

  typedef struct packed {
    logic load;
    logic mac;
    logic pass;
  } cell_ctrl_t;

endpackage

// ===== design/lkdf_front.sv =====
// Line stores and gradient stage: forms Ix, Iy, It and the newest window column.
// Depends on lkdf_pkg.
module lkdf_front import lkdf_pkg::*; #(
  parameter int MAX_WIDTH   = DEF_MAX_WIDTH,
  parameter int WINDOW_SIZE = DEF_WINDOW_SIZE,
  localparam int COL_W  = $clog2(MAX_WIDTH),
  localparam int BANKS  = WINDOW_SIZE - 1,
  localparam int SLOT_W = $clog2(BANKS)
) (
  input  logic                           clk,
  input  front_ctrl_t                    ctrl,
  input  logic [COL_W-1:0]               col,
  input  logic [2*PIX_W-1:0]             cur,
  input  logic [SLOT_W-1:0]              slot,
  output logic [WINDOW_SIZE*ENTRY_W-1:0] new_col
);

  logic [2*PIX_W-1:0] raw_mem [MAX_WIDTH];
  logic [ENTRY_W-1:0] grad_mem [BANKS][MAX_WIDTH];

  logic [2*PIX_W-1:0] up_q, cur_q, left_up, left_cur;
  logic [COL_W-1:0]   col_q;
  logic [ENTRY_W-1:0] bank_q [BANKS];
  logic [ENTRY_W-1:0] g;

  logic [PIX_W:0]   sa, sb, sc, sd;
  logic [PIX_W+1:0] sum_now, sum_before;
  logic [11:0]      ix, iy, it;

  // The pixel pair read back is the one above; the write replaces it.
  always_ff @(posedge clk) begin
    if (ctrl.capture) begin
      up_q <= raw_mem[col];
      raw_mem[col] <= cur;
      cur_q <= cur;
      col_q <= col;
    end
    if (ctrl.commit) begin
      left_up  <= up_q;
      left_cur <= cur_q;
    end
  end

  always_ff @(posedge clk) begin
    for (int b = 0; b < BANKS; b++) begin
      if (ctrl.capture) begin
        bank_q[b] <= grad_mem[b][col];
      end
      if (ctrl.commit && SLOT_W'(b) == slot) begin
        grad_mem[b][col_q] <= g;
      end
    end
  end

  always_comb begin
    sa = {1'b0, left_up[2*PIX_W-1:PIX_W]}  + {1'b0, left_up[PIX_W-1:0]};
    sb = {1'b0, up_q[2*PIX_W-1:PIX_W]}     + {1'b0, up_q[PIX_W-1:0]};
    sc = {1'b0, left_cur[2*PIX_W-1:PIX_W]} + {1'b0, left_cur[PIX_W-1:0]};
    sd = {1'b0, cur_q[2*PIX_W-1:PIX_W]}    + {1'b0, cur_q[PIX_W-1:0]};
    sum_now = 10'(left_up[2*PIX_W-1:PIX_W]) + 10'(up_q[2*PIX_W-1:PIX_W])
            + 10'(left_cur[2*PIX_W-1:PIX_W]) + 10'(cur_q[2*PIX_W-1:PIX_W]);
    sum_before = 10'(left_up[PIX_W-1:0]) + 10'(up_q[PIX_W-1:0])
               + 10'(left_cur[PIX_W-1:0]) + 10'(cur_q[PIX_W-1:0]);
    // Two's complement wraps cleanly; only the low 11 bits are kept.
    ix = 12'(sb) - 12'(sa) + 12'(sd) - 12'(sc);
    iy = 12'(sc) + 12'(sd) - 12'(sa) - 12'(sb);
    it = 12'(sum_now) - 12'(sum_before);
    g  = ctrl.grad_on ? {it[GRAD_W-1:0], iy[GRAD_W-1:0], ix[GRAD_W-1:0]} : '0;
  end

  // The bank at slot holds the oldest row; the others follow in rotation.
  always_comb begin
    logic [SLOT_W:0] sel;
    new_col = '0;
    for (int j = 0; j < BANKS; j++) begin
      sel = {1'b0, slot} + (SLOT_W+1)'(j);
      if (sel >= (SLOT_W+1)'(BANKS)) begin
        sel = sel - (SLOT_W+1)'(BANKS);
      end
      new_col[j*ENTRY_W +: ENTRY_W] = bank_q[sel[SLOT_W-1:0]];
    end
    new_col[BANKS*ENTRY_W +: ENTRY_W] = g;
  end

endmodule

// ===== design/lkdf_cell.sv =====
// One window column: holds its gradients, forms its five product sums,
// and hands column and sums to the next cell. Depends on lkdf_pkg.
module lkdf_cell import lkdf_pkg::*; #(
  parameter int WINDOW_SIZE = DEF_WINDOW_SIZE,
  parameter int SUM_W       = 27
) (
  input  logic                           clk,
  input  cell_ctrl_t                     ctrl,
  input  logic [WINDOW_SIZE*ENTRY_W-1:0] col_in,
  output logic [WINDOW_SIZE*ENTRY_W-1:0] col_out,
  input  logic [NUM_SUMS*SUM_W-1:0]      acc_in,
  output logic [NUM_SUMS*SUM_W-1:0]      acc_out
);

  logic [ENTRY_W-1:0]        ent [WINDOW_SIZE];
  logic signed [SUM_W-1:0]   acc [NUM_SUMS];
  logic signed [GRAD_W-1:0]  gx, gy, gt;
  logic signed [2*GRAD_W-1:0] prod [NUM_SUMS];

  always_comb begin
    gx = $signed(ent[0][GRAD_W-1:0]);
    gy = $signed(ent[0][2*GRAD_W-1:GRAD_W]);
    gt = $signed(ent[0][3*GRAD_W-1:2*GRAD_W]);
    prod[0] = gx * gx;
    prod[1] = gx * gy;
    prod[2] = gy * gy;
    prod[3] = gx * gt;
    prod[4] = gy * gt;
  end

  // Accumulation rotates the column once around, leaving it as loaded.
  always_ff @(posedge clk) begin
    priority if (ctrl.load) begin
      for (int k = 0; k < WINDOW_SIZE; k++) begin
        ent[k] <= col_in[k*ENTRY_W +: ENTRY_W];
      end
      for (int n = 0; n < NUM_SUMS; n++) begin
        acc[n] <= '0;
      end
    end else if (ctrl.mac) begin
      for (int k = 0; k < WINDOW_SIZE - 1; k++) begin
        ent[k] <= ent[k+1];
      end
      ent[WINDOW_SIZE-1] <= ent[0];
      for (int n = 0; n < NUM_SUMS; n++) begin
        acc[n] <= acc[n] + {{(SUM_W-2*GRAD_W){prod[n][2*GRAD_W-1]}}, prod[n]};
      end
    end else if (ctrl.pass) begin
      for (int n = 0; n < NUM_SUMS; n++) begin
        acc[n] <= $signed(acc_in[n*SUM_W +: SUM_W]);
      end
    end
  end

  always_comb begin
    for (int k = 0; k < WINDOW_SIZE; k++) begin
      col_out[k*ENTRY_W +: ENTRY_W] = ent[k];
    end
    for (int n = 0; n < NUM_SUMS; n++) begin
      acc_out[n*SUM_W +: SUM_W] = acc[n];
    end
  end

endmodule

// ===== design/lkdf_divider.sv =====
// Restoring divider, one quotient bit a cycle, with rounding and saturation
// of the flow result to signed fixed point. Depends on lkdf_pkg.
module lkdf_divider import lkdf_pkg::*; #(
  parameter int NUM_W         = 55,
  parameter int FRACTION_BITS = DEF_FRACTION_BITS
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [NUM_W-1:0]  num,
  input  logic [NUM_W-1:0]  den,
  output logic              done,
  output logic [FLOW_W-1:0] quo
);

  localparam int STEPS = NUM_W + FRACTION_BITS + 1;
  localparam int CNT_W = $clog2(STEPS);

  logic              run, neg, over;
  logic [CNT_W-1:0]  cnt;
  logic [NUM_W-1:0]  dividend, divisor, rem;
  logic [FLOW_W:0]   q;
  logic [NUM_W:0]    trial;
  logic              fits;
  logic [FLOW_W+1:0] rnd;
  logic [FLOW_W:0]   mag;

  assign trial = {rem, dividend[NUM_W-1]};
  assign fits  = trial >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else if (start) begin
      run  <= 1'b1;
      done <= 1'b0;
    end else if (run && cnt == CNT_W'(STEPS - 1)) begin
      run  <= 1'b0;
      done <= 1'b1;
    end
  end

  // Zeros shift in behind the numerator and supply the fraction bits.
  always_ff @(posedge clk) begin
    if (start) begin
      dividend <= num[NUM_W-1] ? ~num + 1'b1 : num;
      divisor  <= den[NUM_W-1] ? ~den + 1'b1 : den;
      neg      <= num[NUM_W-1] ^ den[NUM_W-1];
      rem      <= '0;
      q        <= '0;
      over     <= 1'b0;
      cnt      <= '0;
    end else if (run) begin
      dividend <= {dividend[NUM_W-2:0], 1'b0};
      rem      <= fits ? NUM_W'(trial - {1'b0, divisor}) : trial[NUM_W-1:0];
      q        <= {q[FLOW_W-1:0], fits};
      over     <= over | q[FLOW_W];
      cnt      <= cnt + 1'b1;
    end
  end

  // The quotient carries one extra fraction bit for round half away from zero.
  always_comb begin
    rnd = {1'b0, q} + 1'b1;
    mag = rnd[FLOW_W+1:1];
    if (neg) begin
      if (over || mag[FLOW_W] || (mag[FLOW_W-1] && |mag[FLOW_W-2:0])) begin
        quo = {1'b1, {(FLOW_W-1){1'b0}}};
      end else begin
        quo = ~mag[FLOW_W-1:0] + 1'b1;
      end
    end else begin
      if (over || mag[FLOW_W] || mag[FLOW_W-1]) begin
        quo = {1'b0, {(FLOW_W-1){1'b1}}};
      end else begin
        quo = mag[FLOW_W-1:0];
      end
    end
  end

endmodule

// ===== design/lucas_kanade_dense_flow.sv =====
// Top level of the dense optical flow block: configuration, sequencer, cell row,
// solver. Depends on lkdf_pkg, lkdf_front, lkdf_cell, lkdf_divider and the defines.
//
// Pixels of the current and previous frame come in raster order, one beat per
// pixel, and the block works on one pixel at a time. A pixel that yields no
// result passes through accept and the gradient and line store update. A pixel
// that yields a result goes on: the row of WINDOW_SIZE column cells forms its
// product sums and passes them down the chain, then the shared solver multiplies,
// and the two bit-serial dividers run; a singular window skips the dividers.
// A finished result waits in the output register while the next pixel is taken.
// Line stores need no clearing after reset.
`include "lucas_kanade_dense_flow_defines.svh"

module lucas_kanade_dense_flow import lkdf_pkg::*; #(
  parameter int MAX_WIDTH     = DEF_MAX_WIDTH,
  parameter int WINDOW_SIZE   = DEF_WINDOW_SIZE,
  parameter int FRACTION_BITS = DEF_FRACTION_BITS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // pixel_now [7:0], pixel_before [15:8]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [87:0] m_tdata,   // flow_u [31:0], flow_v [63:32], out_row [75:64],
                                 // out_col [85:76], zero fill [87:86]
  output logic [0:0]  m_tuser,   // singular [0]
  output logic        m_tlast,   // frame_end
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int COL_W    = $clog2(MAX_WIDTH);
  localparam int BANKS    = WINDOW_SIZE - 1;
  localparam int SLOT_W   = $clog2(BANKS);
  localparam int WIN_HALF = WINDOW_SIZE / 2;
  localparam int WIN_LEAD = WINDOW_SIZE - 1 - WIN_HALF;
  localparam int SUM_W    = 2 * GRAD_W + $clog2(WINDOW_SIZE * WINDOW_SIZE);
  localparam int PROD_W   = 2 * SUM_W;
  localparam int NUM_W    = PROD_W + 1;
  localparam int STEP_W   = $clog2(WINDOW_SIZE);

  state_t state, state_next;

  logic [WIDTH_REG_W-1:0]  image_width;
  logic [HEIGHT_REG_W-1:0] image_height;
  logic [ROW_W-1:0]        row_cnt;
  logic [COL_W-1:0]        col_cnt;
  logic [SLOT_W-1:0]       slot;
  logic [STEP_W-1:0]       step;

  logic signed [SUM_W-1:0]  tot [NUM_SUMS];
  logic signed [PROD_W-1:0] prod [6];
  logic signed [NUM_W-1:0]  det, num_u, num_v;

  logic [ROW_W-1:0]     res_row;
  logic [OUT_COL_W-1:0] res_col;
  logic                 res_end, res_sing;

  logic [FLOW_W-1:0]    out_u, out_v;
  logic [ROW_W-1:0]     out_row;
  logic [OUT_COL_W-1:0] out_col;
  logic                 out_sing, out_last;

  logic [DIM_W-1:0] w_eff, h_eff, r_ext, c_ext, col_inc, row_inc, row_off, col_off;
  logic             has_result, frame_last, last_step;

  front_ctrl_t fctrl;
  cell_ctrl_t  cctrl;
  logic        div_start, out_load, done_u, done_v;
  logic [FLOW_W-1:0] quo_u, quo_v;

  logic [WINDOW_SIZE*ENTRY_W-1:0] new_col;
  logic [WINDOW_SIZE*ENTRY_W-1:0] col_chain [WINDOW_SIZE];
  logic [NUM_SUMS*SUM_W-1:0]      acc_chain [WINDOW_SIZE+1];

  // Configuration port.
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= RESET_WIDTH;
      image_height <= RESET_HEIGHT;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[2])
        REG_IMAGE_WIDTH:  image_width  <= pwdata[WIDTH_REG_W-1:0];
        REG_IMAGE_HEIGHT: image_height <= pwdata[HEIGHT_REG_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_IMAGE_WIDTH:  prdata = 32'(image_width);
      REG_IMAGE_HEIGHT: prdata = 32'(image_height);
    endcase
  end

  // Frame geometry and the window test for the pixel being worked on.
  always_comb begin
    w_eff = DIM_W'(image_width);
    if (w_eff < DIM_W'(MIN_DIM)) begin
      w_eff = DIM_W'(MIN_DIM);
    end else if (w_eff > DIM_W'(MAX_WIDTH)) begin
      w_eff = DIM_W'(MAX_WIDTH);
    end
    h_eff = DIM_W'(image_height);
    if (h_eff < DIM_W'(MIN_DIM)) begin
      h_eff = DIM_W'(MIN_DIM);
    end else if (h_eff > DIM_W'(MAX_HEIGHT)) begin
      h_eff = DIM_W'(MAX_HEIGHT);
    end
    r_ext   = DIM_W'(row_cnt);
    c_ext   = DIM_W'(col_cnt);
    col_inc = c_ext + 1'b1;
    row_inc = r_ext + 1'b1;
    row_off = r_ext - DIM_W'(WIN_LEAD);
    col_off = c_ext - DIM_W'(WIN_LEAD);
    has_result = r_ext >= DIM_W'(WINDOW_SIZE - 1) && c_ext >= DIM_W'(WINDOW_SIZE - 1)
              && r_ext + DIM_W'(WIN_HALF + 2) <= h_eff
              && c_ext + DIM_W'(WIN_HALF + 2) <= w_eff;
    frame_last = r_ext + DIM_W'(WIN_HALF + 2) == h_eff
              && c_ext + DIM_W'(WIN_HALF + 2) == w_eff;
    last_step  = step == STEP_W'(WINDOW_SIZE - 1);
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next    = state;
    fctrl.capture = 1'b0;
    fctrl.commit  = 1'b0;
    fctrl.grad_on = r_ext >= DIM_W'(2) && c_ext >= DIM_W'(2);
    cctrl.load    = 1'b0;
    cctrl.mac     = 1'b0;
    cctrl.pass    = 1'b0;
    div_start     = 1'b0;
    out_load      = 1'b0;
    s_tready      = 1'b0;
    unique case (state)
      ST_IDLE: begin
        s_tready      = 1'b1;
        fctrl.capture = s_tvalid;
        if (s_tvalid) begin
          state_next = ST_GRAD;
        end
      end
      ST_GRAD: begin
        fctrl.commit = 1'b1;
        cctrl.load   = 1'b1;
        state_next   = has_result ? ST_MAC : ST_IDLE;
      end
      ST_MAC: begin
        cctrl.mac = 1'b1;
        if (last_step) begin
          state_next = ST_RED;
        end
      end
      ST_RED: begin
        cctrl.pass = 1'b1;
        if (last_step) begin
          state_next = ST_MUL;
        end
      end
      ST_MUL:  state_next = ST_DIFF;
      ST_DIFF: state_next = ST_CHK;
      ST_CHK: begin
        if (det == '0) begin
          state_next = ST_OUT;
        end else begin
          div_start  = 1'b1;
          state_next = ST_DIV;
        end
      end
      ST_DIV: begin
        if (done_u && done_v) begin
          state_next = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!m_tvalid || m_tready) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Pixel position; slot tracks the row modulo the number of stored rows.
  always_ff @(posedge clk) begin
    if (rst) begin
      row_cnt <= '0;
      col_cnt <= '0;
      slot    <= '0;
      step    <= '0;
    end else begin
      if (state == ST_GRAD) begin
        if (col_inc >= w_eff) begin
          col_cnt <= '0;
          if (row_inc >= h_eff) begin
            row_cnt <= '0;
            slot    <= '0;
          end else begin
            row_cnt <= row_inc[ROW_W-1:0];
            slot    <= (slot == SLOT_W'(BANKS - 1)) ? '0 : slot + 1'b1;
          end
        end else begin
          col_cnt <= col_inc[COL_W-1:0];
        end
      end
      if (state == ST_MAC || state == ST_RED) begin
        step <= last_step ? '0 : step + 1'b1;
      end else begin
        step <= '0;
      end
    end
  end

  // Window sums, solver products and result fields.
  always_ff @(posedge clk) begin
    if (state == ST_GRAD) begin
      res_row <= row_off[ROW_W-1:0];
      res_col <= col_off[OUT_COL_W-1:0];
      res_end <= frame_last;
      for (int n = 0; n < NUM_SUMS; n++) begin
        tot[n] <= '0;
      end
    end
    if (state == ST_RED) begin
      for (int n = 0; n < NUM_SUMS; n++) begin
        tot[n] <= tot[n] + $signed(acc_chain[WINDOW_SIZE][n*SUM_W +: SUM_W]);
      end
    end
    // tot order: xx, xy, yy, xt, yt
    if (state == ST_MUL) begin
      prod[0] <= tot[0] * tot[2];
      prod[1] <= tot[1] * tot[1];
      prod[2] <= tot[1] * tot[4];
      prod[3] <= tot[2] * tot[3];
      prod[4] <= tot[1] * tot[3];
      prod[5] <= tot[0] * tot[4];
    end
    if (state == ST_DIFF) begin
      det   <= NUM_W'(prod[0]) - NUM_W'(prod[1]);
      num_u <= NUM_W'(prod[2]) - NUM_W'(prod[3]);
      num_v <= NUM_W'(prod[4]) - NUM_W'(prod[5]);
    end
    if (state == ST_CHK) begin
      res_sing <= det == '0;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_u    <= res_sing ? '0 : quo_u;
      out_v    <= res_sing ? '0 : quo_v;
      out_row  <= res_row;
      out_col  <= res_col;
      out_sing <= res_sing;
      out_last <= res_end;
    end
  end

  assign m_tdata    = {2'b00, out_col, out_row, out_v, out_u};
  assign m_tuser[0] = out_sing;
  assign m_tlast    = out_last;

  lkdf_front #(
    .MAX_WIDTH   (MAX_WIDTH),
    .WINDOW_SIZE (WINDOW_SIZE)
  ) u_front (
    .clk     (clk),
    .ctrl    (fctrl),
    .col     (col_cnt),
    .cur     ({s_tdata[7:0], s_tdata[15:8]}),
    .slot    (slot),
    .new_col (new_col)
  );

  assign acc_chain[0] = '0;

  for (genvar k = 0; k < WINDOW_SIZE; k++) begin : g_cell
    lkdf_cell #(
      .WINDOW_SIZE (WINDOW_SIZE),
      .SUM_W       (SUM_W)
    ) u_cell (
      .clk     (clk),
      .ctrl    (cctrl),
      .col_in  ((k == 0) ? new_col : col_chain[(k == 0) ? 0 : k - 1]),
      .col_out (col_chain[k]),
      .acc_in  (acc_chain[k]),
      .acc_out (acc_chain[k+1])
    );
  end

  lkdf_divider #(
    .NUM_W         (NUM_W),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_div_u (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (num_u),
    .den   (det),
    .done  (done_u),
    .quo   (quo_u)
  );

  lkdf_divider #(
    .NUM_W         (NUM_W),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_div_v (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (num_v),
    .den   (det),
    .done  (done_v),
    .quo   (quo_v)
  );

  // An accepted pixel always goes straight to the gradient step.
  `LKDF_ASSERT_NXT(a_accept_to_grad, s_tvalid && s_tready, state == ST_GRAD && !s_tready)
  // A singular window never carries a nonzero flow.
  `LKDF_ASSERT_IMP(a_singular_zero, m_tvalid && m_tuser[0], m_tdata[63:0] == 64'd0)
  // A waiting result is not overwritten by the next one.
  `LKDF_ASSERT_NXT(a_out_holds, state == ST_OUT && m_tvalid && !m_tready, state == ST_OUT)

endmodule
